// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the heap allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SHA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment heap allocator package
// Sizes, codes and the structs shared by the controller and the cell chain.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int HEADER_BYTES = 32;
   localparam int ADDRESS_BITS = 20;

   localparam int IDX_W      = $clog2(MAX_SEGMENTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ADDR_W     = ADDRESS_BITS;
   localparam int NEED_W     = ADDR_W + 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = NEED_W;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [NEED_W-1:0] need_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // Largest heap extent the address space allows.
   localparam need_type HEAP_SPAN = need_type'(1) << ADDR_W;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_FIT_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NULL,
      STATUS_NO_MEMORY,
      STATUS_INVALID
   } status_type;

   typedef enum logic [1:0] {
      FIT_FIRST,
      FIT_NEXT,
      FIT_BEST,
      FIT_WORST
   } policy_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_WRITE,
      OP_FREE,
      OP_ALLOC,
      OP_SPLIT,
      OP_MERGE
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MERGE_NEXT,
      ST_MERGE_PREV,
      ST_RESP
   } state_type;

   // One table entry.
   typedef struct packed {
      addr_type start;
      addr_type size;
      logic     free;
   } seg_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      cell_op_type op;
      idx_type     idx;
      addr_type    start;
      addr_type    size;
      need_type    need;
      addr_type    addr;
      cnt_type     count;
      policy_type  policy;
      idx_type     nf_first;
   } cell_cmd_type;

   // Search result handed from cell to cell.
   typedef struct packed {
      logic     found;
      logic     lo;
      idx_type  pidx;
      addr_type pstart;
      addr_type psize;
      need_type gap;
      logic     match;
      idx_type  midx;
      logic     mfree;
      logic     mprev;
      logic     mnext;
   } token_type;

endpackage

// ===== hw/rtl/sha_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries allocate and release commands.
// ----------------------------------------------------------------------------
interface sha_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   sha_pkg::addr_type request_size;
   sha_pkg::addr_type release_address;

   modport source (output valid, command, request_size, release_address, input ready);
   modport sink   (input valid, command, request_size, release_address, output ready);
endinterface

// ===== hw/rtl/sha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result per command.
// ----------------------------------------------------------------------------
interface sha_rsp_if;
   logic                valid;
   logic                ready;
   sha_pkg::status_type status;
   sha_pkg::addr_type   result_address;
   logic                reused;
   logic                split_done;
   logic                grew;
   logic [1:0]          merges;

   modport source (output valid, status, result_address, reused, split_done, grew, merges,
                   input ready);
   modport sink   (input valid, status, result_address, reused, split_done, grew, merges,
                   output ready);
endinterface

// ===== hw/rtl/segment_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Segment heap allocator core
// Address-ordered segment table in a row of cells with a sequencing controller.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake        Carries
//   req_if    in         valid / ready    command, request_size, release_address
//   rsp_if    out        valid / ready    status, address, reuse/split/grow, merges
//   csr_*     in         write enable     fit_policy (index 0), heap_limit (index 1)
//
// A null or zero-size item goes straight to the response state. Any other item
// runs one search wave that crosses all 64 cells, one register per cell; the
// table update is issued as the wave ends, then the response follows. A release
// that frees a segment passes the merge-next and merge-prev states for neighbor
// merges. One item is in flight at a time; a stalled response holds the block.
// Reset is synchronous and empties the table at once; no clearing pass.
module segment_heap_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   sha_req_if.sink                        req_if,
   sha_rsp_if.source                      rsp_if,
   input  logic                           csr_write_enable,
   input  logic [sha_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sha_pkg::CSR_DATA_W-1:0] csr_write_data
);

   sha_pkg::cell_cmd_type bc;
   sha_pkg::seg_type      seg_w [sha_pkg::MAX_SEGMENTS];
   sha_pkg::token_type    tok_w [sha_pkg::MAX_SEGMENTS+1];

   assign tok_w[0] = '0;

   sha_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .bc               (bc),
      .tok_last         (tok_w[sha_pkg::MAX_SEGMENTS])
   );

   // Row of cells; each sees its two neighbors' entries.
   for (genvar i = 0; i < sha_pkg::MAX_SEGMENTS; i++) begin : g_cell
      sha_pkg::seg_type left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = seg_w[i-1];
      end
      if (i == sha_pkg::MAX_SEGMENTS - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = seg_w[i+1];
      end
      sha_cell u_cell (
         .clock     (clock),
         .cell_idx  (sha_pkg::IDX_W'(i)),
         .bc        (bc),
         .left_seg  (left_w),
         .right_seg (right_w),
         .tok_in    (tok_w[i]),
         .seg       (seg_w[i]),
         .tok_out   (tok_w[i+1])
      );
   end

endmodule

// ===== hw/rtl/sha_cell.sv =====
// ----------------------------------------------------------------------------
// Segment cell
// Holds one table entry, takes part in the search wave and in table shifts.
// ----------------------------------------------------------------------------
module sha_cell (
   input  logic                  clock,
   input  sha_pkg::idx_type      cell_idx,
   input  sha_pkg::cell_cmd_type bc,
   input  sha_pkg::seg_type      left_seg,
   input  sha_pkg::seg_type      right_seg,
   input  sha_pkg::token_type    tok_in,
   output sha_pkg::seg_type      seg,
   output sha_pkg::token_type    tok_out
);

   sha_pkg::seg_type   seg_ff, seg_in;
   sha_pkg::token_type tok_ff, tok_step_in;
   sha_pkg::cnt_type   my_idx, sel;
   sha_pkg::need_type  size_w, gap;
   logic               valid, fits, hi, take, match;

   // Search step: fold this entry into the result passed from the left.
   always_comb begin
      my_idx = {1'b0, cell_idx};
      sel    = {1'b0, bc.idx};
      valid  = my_idx < bc.count;
      size_w = {1'b0, seg_ff.size};
      fits   = valid && seg_ff.free && (size_w >= bc.need);
      gap    = size_w - bc.need;
      hi     = cell_idx >= bc.nf_first;
      unique case (bc.policy)
         sha_pkg::FIT_FIRST: take = !tok_in.found;
         sha_pkg::FIT_NEXT:  take = !tok_in.found || (tok_in.lo && hi);
         sha_pkg::FIT_BEST:  take = !tok_in.found || (gap < tok_in.gap);
         sha_pkg::FIT_WORST: take = !tok_in.found || (gap > tok_in.gap);
         default:            take = 1'b0;
      endcase
      match = valid && !tok_in.match &&
              (({1'b0, seg_ff.start} + sha_pkg::NEED_W'(sha_pkg::HEADER_BYTES)) ==
               {1'b0, bc.addr});
      tok_step_in = tok_in;
      if (fits && take) begin
         tok_step_in.found  = 1'b1;
         tok_step_in.lo     = !hi;
         tok_step_in.pidx   = cell_idx;
         tok_step_in.pstart = seg_ff.start;
         tok_step_in.psize  = seg_ff.size;
         tok_step_in.gap    = gap;
      end
      if (match) begin
         tok_step_in.match = 1'b1;
         tok_step_in.midx  = cell_idx;
         tok_step_in.mfree = seg_ff.free;
         tok_step_in.mprev = left_seg.free;
         tok_step_in.mnext = right_seg.free && ((my_idx + sha_pkg::CNT_W'(1)) < bc.count);
      end
   end

   // Table update: local writes and whole-row shifts.
   always_comb begin
      seg_in = seg_ff;
      unique case (bc.op)
         sha_pkg::OP_NOP: begin
         end
         sha_pkg::OP_WRITE: begin
            if (my_idx == sel) begin
               seg_in.start = bc.start;
               seg_in.size  = bc.size;
               seg_in.free  = 1'b0;
            end
         end
         sha_pkg::OP_FREE: begin
            if (my_idx == sel) seg_in.free = 1'b1;
         end
         sha_pkg::OP_ALLOC: begin
            if (my_idx == sel) seg_in.free = 1'b0;
         end
         sha_pkg::OP_SPLIT: begin
            if (my_idx == sel) begin
               seg_in.size = bc.need[sha_pkg::ADDR_W-1:0];
               seg_in.free = 1'b0;
            end else if (my_idx == sel + sha_pkg::CNT_W'(1)) begin
               seg_in.start = left_seg.start + sha_pkg::ADDR_W'(sha_pkg::HEADER_BYTES) +
                              bc.need[sha_pkg::ADDR_W-1:0];
               seg_in.size  = left_seg.size - bc.need[sha_pkg::ADDR_W-1:0] -
                              sha_pkg::ADDR_W'(sha_pkg::HEADER_BYTES);
               seg_in.free  = 1'b1;
            end else if (my_idx > sel + sha_pkg::CNT_W'(1)) begin
               seg_in = left_seg;
            end
         end
         sha_pkg::OP_MERGE: begin
            if (my_idx + sha_pkg::CNT_W'(1) == sel) begin
               seg_in.size = seg_ff.size + right_seg.size +
                             sha_pkg::ADDR_W'(sha_pkg::HEADER_BYTES);
            end else if (my_idx >= sel) begin
               seg_in = right_seg;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
      tok_ff <= tok_step_in;
   end

   assign seg     = seg_ff;
   assign tok_out = tok_ff;

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the search wave, the table update and the response for one item.
// ----------------------------------------------------------------------------
module sha_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   sha_req_if.sink                               req_if,
   sha_rsp_if.source                             rsp_if,
   input  logic                                  csr_write_enable,
   input  logic [sha_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sha_pkg::CSR_DATA_W-1:0]        csr_write_data,
   output sha_pkg::cell_cmd_type                 bc,
   input  sha_pkg::token_type                    tok_last
);

   sha_pkg::state_type  state_ff, state_in;
   sha_pkg::cnt_type    cnt_ff, cnt_in;
   logic                cmd_ff, cmd_in;
   sha_pkg::need_type   need_ff, need_in;
   sha_pkg::addr_type   addr_ff, addr_in;
   sha_pkg::cnt_type    count_ff, count_in;
   sha_pkg::need_type   top_ff, top_in;
   sha_pkg::cnt_type    nfi_ff, nfi_in;
   sha_pkg::policy_type policy_ff, policy_in;
   sha_pkg::need_type   limit_ff, limit_in;
   sha_pkg::idx_type    hit_ff, hit_in;
   logic                do_next_ff, do_next_in, do_prev_ff, do_prev_in;
   sha_pkg::status_type status_ff, status_in;
   sha_pkg::addr_type   raddr_ff, raddr_in;
   logic                reused_ff, reused_in, split_ff, split_in, grew_ff, grew_in;
   logic [1:0]          merges_ff, merges_in;

   sha_pkg::need_type          round_need, cap;
   logic [sha_pkg::NEED_W:0]   grow_end;
   sha_pkg::cnt_type           j;
   logic                       do_split;

   // Next state, cell commands and response fields.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd_in     = cmd_ff;
      need_in    = need_ff;
      addr_in    = addr_ff;
      count_in   = count_ff;
      top_in     = top_ff;
      nfi_in     = nfi_ff;
      policy_in  = policy_ff;
      limit_in   = limit_ff;
      hit_in     = hit_ff;
      do_next_in = do_next_ff;
      do_prev_in = do_prev_ff;
      status_in  = status_ff;
      raddr_in   = raddr_ff;
      reused_in  = reused_ff;
      split_in   = split_ff;
      grew_in    = grew_ff;
      merges_in  = merges_ff;

      bc          = '0;
      bc.op       = sha_pkg::OP_NOP;
      bc.need     = need_ff;
      bc.addr     = addr_ff;
      bc.count    = count_ff;
      bc.policy   = policy_ff;
      bc.nf_first = (nfi_ff < count_ff) ? nfi_ff[sha_pkg::IDX_W-1:0] : '0;

      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;

      round_need = ({1'b0, req_if.request_size} + sha_pkg::NEED_W'(3)) &
                   ~sha_pkg::NEED_W'(3);
      cap        = (limit_ff > sha_pkg::HEAP_SPAN) ? sha_pkg::HEAP_SPAN : limit_ff;
      grow_end   = {1'b0, top_ff} + (sha_pkg::NEED_W + 1)'(sha_pkg::HEADER_BYTES) +
                   {1'b0, need_ff};
      do_split   = (tok_last.gap > sha_pkg::NEED_W'(sha_pkg::HEADER_BYTES)) &&
                   (count_ff < sha_pkg::CNT_W'(sha_pkg::MAX_SEGMENTS));
      j          = '0;

      // The user must write the registers only while no item is in flight; the block does not enforce it.
      if (csr_write_enable) begin
         unique case (csr_index)
            sha_pkg::REG_FIT_POLICY: policy_in = sha_pkg::policy_type'(csr_write_data[1:0]);
            sha_pkg::REG_HEAP_LIMIT: limit_in  = csr_write_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               cmd_in    = req_if.command;
               need_in   = round_need;
               addr_in   = req_if.release_address;
               cnt_in    = '0;
               status_in = sha_pkg::STATUS_OK;
               raddr_in  = '0;
               reused_in = 1'b0;
               split_in  = 1'b0;
               grew_in   = 1'b0;
               merges_in = '0;
               if ((req_if.command == sha_pkg::CMD_ALLOC && round_need == '0) ||
                   (req_if.command == sha_pkg::CMD_RELEASE && req_if.release_address == '0))
               begin
                  status_in = sha_pkg::STATUS_NULL;
                  state_in  = sha_pkg::ST_RESP;
               end else begin
                  state_in = sha_pkg::ST_SCAN;
               end
            end
         end

         sha_pkg::ST_SCAN: begin
            if (cnt_ff != sha_pkg::CNT_W'(sha_pkg::MAX_SEGMENTS)) begin
               cnt_in = cnt_ff + sha_pkg::CNT_W'(1);
            end else if (cmd_ff == sha_pkg::CMD_ALLOC) begin
               state_in = sha_pkg::ST_RESP;
               if (tok_last.found) begin
                  // Reuse a free segment, splitting off the leftover when it pays.
                  bc.idx    = tok_last.pidx;
                  bc.op     = do_split ? sha_pkg::OP_SPLIT : sha_pkg::OP_ALLOC;
                  reused_in = 1'b1;
                  split_in  = do_split;
                  raddr_in  = tok_last.pstart + sha_pkg::ADDR_W'(sha_pkg::HEADER_BYTES);
                  if (do_split) begin
                     count_in = count_ff + sha_pkg::CNT_W'(1);
                     if (nfi_ff > {1'b0, tok_last.pidx} && nfi_ff < count_ff)
                        nfi_in = nfi_ff + sha_pkg::CNT_W'(1);
                  end
                  if (policy_ff == sha_pkg::FIT_NEXT) nfi_in = {1'b0, tok_last.pidx};
               end else if (count_ff >= sha_pkg::CNT_W'(sha_pkg::MAX_SEGMENTS) ||
                            grow_end > {1'b0, cap}) begin
                  status_in = sha_pkg::STATUS_NO_MEMORY;
               end else begin
                  // Append a new segment at the heap top.
                  bc.op    = sha_pkg::OP_WRITE;
                  bc.idx   = count_ff[sha_pkg::IDX_W-1:0];
                  bc.start = top_ff[sha_pkg::ADDR_W-1:0];
                  bc.size  = need_ff[sha_pkg::ADDR_W-1:0];
                  count_in = count_ff + sha_pkg::CNT_W'(1);
                  raddr_in = top_ff[sha_pkg::ADDR_W-1:0] +
                             sha_pkg::ADDR_W'(sha_pkg::HEADER_BYTES);
                  top_in   = grow_end[sha_pkg::NEED_W-1:0];
                  grew_in  = 1'b1;
               end
            end else begin
               if (!tok_last.match || tok_last.mfree) begin
                  status_in = sha_pkg::STATUS_INVALID;
                  state_in  = sha_pkg::ST_RESP;
               end else begin
                  bc.op      = sha_pkg::OP_FREE;
                  bc.idx     = tok_last.midx;
                  hit_in     = tok_last.midx;
                  do_next_in = tok_last.mnext;
                  do_prev_in = tok_last.mprev;
                  state_in   = sha_pkg::ST_MERGE_NEXT;
               end
            end
         end

         sha_pkg::ST_MERGE_NEXT: begin
            if (do_next_ff) begin
               j         = {1'b0, hit_ff} + sha_pkg::CNT_W'(1);
               bc.op     = sha_pkg::OP_MERGE;
               bc.idx    = j[sha_pkg::IDX_W-1:0];
               count_in  = count_ff - sha_pkg::CNT_W'(1);
               merges_in = merges_ff + 2'd1;
               if (nfi_ff >= j && nfi_ff < count_ff) nfi_in = nfi_ff - sha_pkg::CNT_W'(1);
            end
            state_in = sha_pkg::ST_MERGE_PREV;
         end

         sha_pkg::ST_MERGE_PREV: begin
            if (do_prev_ff) begin
               j         = {1'b0, hit_ff};
               bc.op     = sha_pkg::OP_MERGE;
               bc.idx    = hit_ff;
               count_in  = count_ff - sha_pkg::CNT_W'(1);
               merges_in = merges_ff + 2'd1;
               if (nfi_ff >= j && nfi_ff < count_ff) nfi_in = nfi_ff - sha_pkg::CNT_W'(1);
            end
            state_in = sha_pkg::ST_RESP;
         end

         sha_pkg::ST_RESP: begin
            rsp_if.valid = 1'b1;
            if (rsp_if.ready) state_in = sha_pkg::ST_IDLE;
         end

         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha_pkg::ST_IDLE;
         count_ff  <= '0;
         top_ff    <= '0;
         nfi_ff    <= sha_pkg::CNT_W'(sha_pkg::MAX_SEGMENTS);
         policy_ff <= sha_pkg::FIT_FIRST;
         limit_ff  <= sha_pkg::HEAP_SPAN;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         top_ff    <= top_in;
         nfi_ff    <= nfi_in;
         policy_ff <= policy_in;
         limit_ff  <= limit_in;
      end
   end

   // Item and response payload.
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      cmd_ff     <= cmd_in;
      need_ff    <= need_in;
      addr_ff    <= addr_in;
      hit_ff     <= hit_in;
      do_next_ff <= do_next_in;
      do_prev_ff <= do_prev_in;
      status_ff  <= status_in;
      raddr_ff   <= raddr_in;
      reused_ff  <= reused_in;
      split_ff   <= split_in;
      grew_ff    <= grew_in;
      merges_ff  <= merges_in;
   end

   assign rsp_if.status         = status_ff;
   assign rsp_if.result_address = raddr_ff;
   assign rsp_if.reused         = reused_ff;
   assign rsp_if.split_done     = split_ff;
   assign rsp_if.grew           = grew_ff;
   assign rsp_if.merges         = merges_ff;

endmodule

// ===== hw/rtl/sha_checker.sv =====
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the response channel of the allocator core and its item ordering.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input sha_pkg::status_type status,
   input sha_pkg::addr_type   result_address,
   input logic                reused,
   input logic                split_done,
   input logic                grew,
   input logic [1:0]          merges
);

   logic rsp_failed, side_clear, kind_ok;

   // Response conditions that the checks below look at.
   assign rsp_failed = rsp_valid && status != sha_pkg::STATUS_OK;
   assign side_clear = result_address == '0 && !reused && !split_done && !grew &&
                       merges == 2'd0;
   assign kind_ok    = !(reused && grew) && (!split_done || reused) &&
                       (merges == 2'd0 || (!reused && !grew));

   // A pending response is not withdrawn.
   `SHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A failed item reports nothing else.
   `SHA_ASSERT_IMPLIES(a_fail_clean, clock, reset, rsp_failed, side_clear)

   // A response never both reuses and grows, only a reuse can split, and merges come with neither.
   `SHA_ASSERT_IMPLIES(a_alloc_kind, clock, reset, rsp_valid, kind_ok)

   // No new item is taken while a response waits.
   `SHA_ASSERT_IMPLIES(a_one_item, clock, reset, rsp_valid, !req_ready)

endmodule

bind segment_heap_allocator_core sha_checker u_sha_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .status         (rsp_if.status),
   .result_address (rsp_if.result_address),
   .reused         (rsp_if.reused),
   .split_done     (rsp_if.split_done),
   .grew           (rsp_if.grew),
   .merges         (rsp_if.merges)
);
